[rtl/obpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpc_pkg
// Shared types, constants and the microcode program for the oriented box
// pose and corner generator.
// ----------------------------------------------------------------------------
package obpc_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int ROT_W    = 18;   // quaternion component, Q2.16
  localparam int ROT_FRAC = 16;
  localparam int AXT_W    = 22;   // rotated axis entry after the drop to 16 fraction bits
  localparam int OPB_W    = 33;   // multiplier operand B width
  localparam int IN_W     = 264;  // packed input item

  // Input item, last declared field (shift_x) in the lowest bits.
  typedef struct packed {
    logic signed [31:0]       grow_z;
    logic signed [31:0]       grow_y;
    logic signed [31:0]       grow_x;
    logic signed [ROT_W-1:0]  turn_z;
    logic signed [ROT_W-1:0]  turn_y;
    logic signed [ROT_W-1:0]  turn_x;
    logic signed [ROT_W-1:0]  turn_w;
    logic signed [31:0]       shift_z;
    logic signed [31:0]       shift_y;
    logic signed [31:0]       shift_x;
  } in_item_t;

  typedef enum logic [1:0] {K_NOP, K_MAC, K_STORE} kind_t;
  typedef enum logic [1:0] {SH_0, SH_1, SH_K} sh_t;
  typedef enum logic [1:0] {A_ROT, A_HALF_LO, A_HALF_HI} asrc_t;
  typedef enum logic [1:0] {B_TURN, B_ROT, B_GROW, B_AXT} bsrc_t;
  typedef enum logic [2:0] {D_NROT, D_ROT, D_HALF, D_AXT, D_OFF} dst_t;

  typedef struct packed {
    kind_t       kind;
    logic        clr;    // start a new sum
    logic        one;    // start the sum at 1.0 (32 fraction bits)
    logic        neg;    // subtract the product
    sh_t         sh;
    asrc_t       asrc;
    logic [1:0]  a_idx;
    bsrc_t       bsrc;
    logic [1:0]  b_idx;
    dst_t        dst;
    logic [3:0]  d_idx;
  } uop_t;

  // Controller to datapath command group.
  typedef struct packed {
    logic        start;   // input transfer: latch item, advance center
    uop_t        uop;
    logic        emit;    // load the output register with a corner
    logic [2:0]  corner;
  } cmd_t;

  localparam int NSTEP  = 92;
  localparam int STEP_W = $clog2(NSTEP);

  typedef uop_t [NSTEP-1:0] rom_t;

  function automatic uop_t nop_uop();
    uop_t u;
    u = '0;
    u.kind = K_NOP;
    return u;
  endfunction

  function automatic uop_t mac(logic clr, logic one, logic neg, sh_t sh,
                               asrc_t asrc, int ai, bsrc_t bsrc, int bi);
    uop_t u;
    u       = '0;
    u.kind  = K_MAC;
    u.clr   = clr;
    u.one   = one;
    u.neg   = neg;
    u.sh    = sh;
    u.asrc  = asrc;
    u.a_idx = 2'(ai);
    u.bsrc  = bsrc;
    u.b_idx = 2'(bi);
    return u;
  endfunction

  function automatic uop_t store(dst_t dst, int idx);
    uop_t u;
    u       = '0;
    u.kind  = K_STORE;
    u.dst   = dst;
    u.d_idx = 4'(idx);
    return u;
  endfunction

  // Rotated axis entry e = row*3+col: {one, a1, b1, n1, a2, b2, n2}
  // with quaternion indexes w=0 x=1 y=2 z=3; every term carries a factor of 2.
  function automatic logic [10:0] axis_terms(int e);
    logic [10:0] t;
    unique case (e)
      0:       t = {1'b1, 2'd2, 2'd2, 1'b1, 2'd3, 2'd3, 1'b1};
      1:       t = {1'b0, 2'd1, 2'd2, 1'b0, 2'd0, 2'd3, 1'b0};
      2:       t = {1'b0, 2'd1, 2'd3, 1'b0, 2'd0, 2'd2, 1'b1};
      3:       t = {1'b0, 2'd1, 2'd2, 1'b0, 2'd0, 2'd3, 1'b1};
      4:       t = {1'b1, 2'd1, 2'd1, 1'b1, 2'd3, 2'd3, 1'b1};
      5:       t = {1'b0, 2'd2, 2'd3, 1'b0, 2'd0, 2'd1, 1'b0};
      6:       t = {1'b0, 2'd1, 2'd3, 1'b0, 2'd0, 2'd2, 1'b0};
      7:       t = {1'b0, 2'd2, 2'd3, 1'b0, 2'd0, 2'd1, 1'b1};
      default: t = {1'b1, 2'd1, 2'd1, 1'b1, 2'd2, 2'd2, 1'b1};
    endcase
    return t;
  endfunction

  // Sign pattern of the Hamilton product, bit c*4+j.
  localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

  function automatic rom_t build_rom();
    rom_t        r;
    int          n;
    logic [10:0] t;
    r = '0;
    n = 0;
    // Rotation: old * turn, component c = sum over j of old[j] * turn[c^j].
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        r[n] = mac(j == 0, 1'b0, HAM_NEG[c*4+j], SH_0, A_ROT, j, B_TURN, c ^ j);
        n++;
      end
      r[n] = (c == 3) ? store(D_ROT, c) : store(D_NROT, c);
      n++;
    end
    // Half extents: two chunks of the stored extent times the factor.
    for (int i = 0; i < 3; i++) begin
      r[n] = mac(1'b1, 1'b0, 1'b0, SH_0, A_HALF_LO, i, B_GROW, i); n++;
      r[n] = mac(1'b0, 1'b0, 1'b0, SH_K, A_HALF_HI, i, B_GROW, i); n++;
      r[n] = store(D_HALF, i); n++;
    end
    // Axis entries and their scaled offsets.
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        t = axis_terms(i*3+k);
        r[n] = mac(1'b1, t[10], t[5], SH_1, A_ROT, int'(t[9:8]), B_ROT, int'(t[7:6]));
        n++;
        r[n] = mac(1'b0, 1'b0, t[0], SH_1, A_ROT, int'(t[4:3]), B_ROT, int'(t[2:1]));
        n++;
        r[n] = store(D_AXT, 0); n++;
        r[n] = nop_uop(); n++;
        r[n] = mac(1'b1, 1'b0, 1'b0, SH_0, A_HALF_LO, i, B_AXT, 0); n++;
        r[n] = mac(1'b0, 1'b0, 1'b0, SH_K, A_HALF_HI, i, B_AXT, 0); n++;
        r[n] = store(D_OFF, i*3+k); n++;
      end
    end
    return r;
  endfunction

  localparam rom_t UOP_ROM = build_rom();

endpackage
`default_nettype wire

[rtl/oriented_box_pose_and_corners_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_box_pose_and_corners_top
// Oriented box pose tracker: each input transfer moves, turns and scales the
// box, then the eight box corners leave as eight result transfers.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------
//   in_     | in  | in_tvalid/tready   | in_tdata: shift, turn, grow
//   out_    | out | out_tvalid/tready  | out_tdata: index, x, y, z; out_tlast
//
// Sequence: an accepted input runs the 92-step program on the single
//   shared multiply-accumulate unit to update the pose, then the eight
//   corners leave in turn.
// Reset: synchronous, active low; pose returns to center zero, identity
//   rotation and unit half extents.
// Stalls: a stalled corner holds in the output register; the sequencer
//   waits. The next input is taken while the eighth corner still waits.
//
module oriented_box_pose_and_corners_top #(
  parameter int  COORD_BITS    = obpc_pkg::COORD_BITS_DEF,
  parameter int  FRACTION_BITS = obpc_pkg::FRACTION_BITS_DEF,
  localparam int OUT_W         = ((3 * COORD_BITS + 3 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // shift_x, shift_y, shift_z, turn_w, turn_x, turn_y, turn_z,
  // grow_x, grow_y, grow_z
  input  logic [obpc_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // corner_index, corner_x, corner_y, corner_z, zero fill
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       out_tlast
);
  import obpc_pkg::*;

  cmd_t                         cmd;
  in_item_t                     in_item;
  logic [2:0]                   corner_index;
  logic signed [COORD_BITS-1:0] corner_x;
  logic signed [COORD_BITS-1:0] corner_y;
  logic signed [COORD_BITS-1:0] corner_z;

  // Unpack the input transfer.
  assign in_item = in_item_t'(in_tdata);

  obpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  obpc_datapath #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_item      (in_item),
    .corner_index (corner_index),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_z     (corner_z),
    .final_corner (out_tlast)
  );

  // Pack the corner, index in the lowest bits, zero fill on top.
  assign out_tdata = OUT_W'({corner_z, corner_y, corner_x, corner_index});

endmodule
`default_nettype wire

[rtl/obpc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpc_ctrl
// Sequencer: steps the microcode program, then hands out eight corners.
// ----------------------------------------------------------------------------
module obpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output obpc_pkg::cmd_t  cmd
);
  import obpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT} state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic [2:0]        corner_r;
  logic              rdy_r;
  logic              ovld_r;
  logic              start;
  logic              emit;

  assign start      = in_tvalid & rdy_r;
  assign emit       = (state_r == S_EMIT) && (!ovld_r || out_tready);
  assign in_tready  = rdy_r;
  assign out_tvalid = ovld_r;

  always_comb begin
    cmd        = '0;
    cmd.start  = start;
    cmd.uop    = (state_r == S_RUN) ? UOP_ROM[step_r] : nop_uop();
    cmd.emit   = emit;
    cmd.corner = corner_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      corner_r <= '0;
      rdy_r    <= 1'b1;
      ovld_r   <= 1'b0;
    end else begin
      if (emit) begin
        ovld_r <= 1'b1;
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            rdy_r   <= 1'b0;
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (step_r == STEP_W'(NSTEP-1)) begin
            state_r <= S_DRAIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DRAIN: begin
          corner_r <= '0;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            corner_r <= corner_r + 1'b1;
            if (corner_r == 3'd7) begin
              rdy_r   <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/obpc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpc_datapath
// Pose registers, shared multiply-accumulate unit and corner output register.
// ----------------------------------------------------------------------------
module obpc_datapath #(
  parameter int COORD_BITS    = obpc_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = obpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  obpc_pkg::cmd_t               cmd,
  input  obpc_pkg::in_item_t           in_item,
  output logic [2:0]                   corner_index,
  output logic signed [COORD_BITS-1:0] corner_x,
  output logic signed [COORD_BITS-1:0] corner_y,
  output logic signed [COORD_BITS-1:0] corner_z,
  output logic                         final_corner
);
  import obpc_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int KC    = (CB + 1) / 2;                  // low chunk of a wide operand
  localparam int MA    = (KC + 1 > ROT_W) ? KC + 1 : ROT_W;
  localparam int PW    = MA + OPB_W;
  localparam int ACC_W = PW + KC + 2;
  localparam int CW    = ((CB > 32) ? CB : 32) + 1;
  localparam int SW    = CB + 2;

  localparam logic signed [ACC_W-1:0] ONE_ACC = {{(ACC_W-33){1'b0}}, 1'b1, {32{1'b0}}};
  localparam logic signed [ACC_W-1:0] R_HI    = {{(ACC_W-ROT_W+1){1'b0}}, {(ROT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] A_HI    = {{(ACC_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [CW-1:0]    C_HI    = {{(CW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SW-1:0]    S_HI    = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};

  logic signed [CB-1:0]     ctr_r  [3];
  logic signed [ROT_W-1:0]  rot_r  [4];
  logic signed [ROT_W-1:0]  nrot_r [3];
  logic signed [CB-1:0]     half_r [3];
  logic signed [ROT_W-1:0]  tq_r   [4];
  logic signed [31:0]       grow_r [3];
  logic signed [AXT_W-1:0]  axt_r;
  logic signed [CB-1:0]     off_r  [9];
  logic signed [PW-1:0]     prod_r;
  uop_t                     pu_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [31:0]       shf [3];
  logic signed [MA-1:0]     a_op;
  logic signed [OPB_W-1:0]  b_op;
  logic signed [PW-1:0]     prod_nxt;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  q16;
  logic signed [ACC_W-1:0]  qfb;
  logic signed [ROT_W-1:0]  rot_sat;
  logic signed [CB-1:0]     ctr_nxt [3];
  logic signed [CB-1:0]     crn_nxt [3];

  function automatic logic signed [CB-1:0] sat_cb(logic signed [ACC_W-1:0] v);
    if (v > A_HI) begin
      return A_HI[CB-1:0];
    end else if (v < ~A_HI) begin
      return ~A_HI[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  assign shf[0] = in_item.shift_x;
  assign shf[1] = in_item.shift_y;
  assign shf[2] = in_item.shift_z;

  // Center advance, saturating.
  always_comb begin
    logic signed [CW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = CW'(ctr_r[i]) + CW'(shf[i]);
      if (s > C_HI) begin
        ctr_nxt[i] = C_HI[CB-1:0];
      end else if (s < ~C_HI) begin
        ctr_nxt[i] = ~C_HI[CB-1:0];
      end else begin
        ctr_nxt[i] = s[CB-1:0];
      end
    end
  end

  // Multiply stage operands.
  always_comb begin
    unique case (cmd.uop.asrc)
      A_ROT:     a_op = MA'(rot_r[cmd.uop.a_idx]);
      A_HALF_LO: a_op = MA'($signed({1'b0, half_r[cmd.uop.a_idx][KC-1:0]}));
      A_HALF_HI: a_op = MA'($signed(half_r[cmd.uop.a_idx][CB-1:KC]));
      default:   a_op = '0;
    endcase
    unique case (cmd.uop.bsrc)
      B_TURN:  b_op = OPB_W'(tq_r[cmd.uop.b_idx]);
      B_ROT:   b_op = OPB_W'(rot_r[cmd.uop.b_idx]);
      B_GROW:  b_op = OPB_W'(grow_r[cmd.uop.b_idx]);
      B_AXT:   b_op = OPB_W'(axt_r);
      default: b_op = '0;
    endcase
  end

  assign prod_nxt = a_op * b_op;

  // Accumulate stage.
  always_comb begin
    unique case (pu_r.sh)
      SH_0:    term = ACC_W'(prod_r);
      SH_1:    term = ACC_W'(prod_r) <<< 1;
      SH_K:    term = ACC_W'(prod_r) <<< KC;
      default: term = '0;
    endcase
    if (pu_r.clr) begin
      base = pu_r.one ? ONE_ACC : '0;
    end else begin
      base = acc_r;
    end
    acc_nxt = pu_r.neg ? base - term : base + term;
    q16     = acc_r >>> ROT_FRAC;
    qfb     = acc_r >>> FRACTION_BITS;
    if (q16 > R_HI) begin
      rot_sat = R_HI[ROT_W-1:0];
    end else if (q16 < ~R_HI) begin
      rot_sat = ~R_HI[ROT_W-1:0];
    end else begin
      rot_sat = q16[ROT_W-1:0];
    end
  end

  // Corner selected by the sequencer; bit 1 flips x axis, bit 2 y, bit 0 z.
  always_comb begin
    logic signed [SW-1:0] s;
    for (int c = 0; c < 3; c++) begin
      s = SW'(ctr_r[c]);
      s = cmd.corner[1] ? s - SW'(off_r[c])   : s + SW'(off_r[c]);
      s = cmd.corner[2] ? s - SW'(off_r[3+c]) : s + SW'(off_r[3+c]);
      s = cmd.corner[0] ? s - SW'(off_r[6+c]) : s + SW'(off_r[6+c]);
      if (s > S_HI) begin
        crn_nxt[c] = S_HI[CB-1:0];
      end else if (s < ~S_HI) begin
        crn_nxt[c] = ~S_HI[CB-1:0];
      end else begin
        crn_nxt[c] = s[CB-1:0];
      end
    end
  end

  // Pose state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ctr_r[i]  <= '0;
        half_r[i] <= CB'(1) <<< FRACTION_BITS;
      end
      rot_r[0] <= ROT_W'(1) <<< ROT_FRAC;
      rot_r[1] <= '0;
      rot_r[2] <= '0;
      rot_r[3] <= '0;
      pu_r     <= nop_uop();
    end else begin
      pu_r <= cmd.uop;
      if (cmd.start) begin
        for (int i = 0; i < 3; i++) begin
          ctr_r[i] <= ctr_nxt[i];
        end
      end
      if (pu_r.kind == K_STORE) begin
        unique case (pu_r.dst)
          D_ROT: begin
            rot_r[0] <= nrot_r[0];
            rot_r[1] <= nrot_r[1];
            rot_r[2] <= nrot_r[2];
            rot_r[3] <= rot_sat;
          end
          D_HALF:  half_r[pu_r.d_idx[1:0]] <= sat_cb(qfb);
          default: ;
        endcase
      end
    end
  end

  // Item operands, products, accumulator and scratch results.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tq_r[0]   <= in_item.turn_w;
      tq_r[1]   <= in_item.turn_x;
      tq_r[2]   <= in_item.turn_y;
      tq_r[3]   <= in_item.turn_z;
      grow_r[0] <= in_item.grow_x;
      grow_r[1] <= in_item.grow_y;
      grow_r[2] <= in_item.grow_z;
    end
    if (cmd.uop.kind == K_MAC) begin
      prod_r <= prod_nxt;
    end
    if (pu_r.kind == K_MAC) begin
      acc_r <= acc_nxt;
    end
    if (pu_r.kind == K_STORE) begin
      unique case (pu_r.dst)
        D_NROT:  nrot_r[pu_r.d_idx[1:0]] <= rot_sat;
        D_AXT:   axt_r <= q16[AXT_W-1:0];
        D_OFF:   off_r[pu_r.d_idx] <= sat_cb(q16);
        default: ;
      endcase
    end
    if (cmd.emit) begin
      corner_index <= cmd.corner;
      corner_x     <= crn_nxt[0];
      corner_y     <= crn_nxt[1];
      corner_z     <= crn_nxt[2];
      final_corner <= &cmd.corner;
    end
  end

endmodule
`default_nettype wire

[rtl/obpc_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpc_chk
// Port-level checks of the box corner generator, bound to the top level.
// ----------------------------------------------------------------------------
module obpc_chk #(
  parameter int OUT_W = 104
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  // A stalled corner holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled corner changed");

  // Busy once an item is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // Only the eighth corner may wait while input is open.
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("input open with corners pending");

  // The run ends on corner seven.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2:0] == 3'd7)
    else $error("last flag on wrong corner");

endmodule

bind oriented_box_pose_and_corners_top obpc_chk #(.OUT_W(OUT_W)) u_chk (.*);
`default_nettype wire

[dv/oriented_box_corner_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_corner_checker
// Watches both channels of the box pose block, tracks the pose on its own
// and compares every corner transfer with the predicted corner.
// ----------------------------------------------------------------------------
module oriented_box_corner_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [obpc_pkg::IN_W-1:0] in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [103:0]              out_tdata,
  input  logic                      out_tlast,
  output int                        fail_count,
  output int                        pending
);
  import obpc_pkg::*;

  typedef struct {
    logic [2:0]         idx;
    logic signed [31:0] x, y, z;
    logic               last;
  } corner_t;

  corner_t corner_q[$];
  longint  ctr[3];
  longint  rot[4];
  longint  half[3];

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mul_floor(longint a, longint b, int s);
    return clip((a * b) >>> s, 32);
  endfunction

  task automatic advance_pose(in_item_t it);
    longint  t[4], nq[4], ax[3][3], off[3][3], w, x, y, z, one, v;
    longint  sg[3];
    corner_t c;
    ctr[0] = clip(ctr[0] + longint'(it.shift_x), 32);
    ctr[1] = clip(ctr[1] + longint'(it.shift_y), 32);
    ctr[2] = clip(ctr[2] + longint'(it.shift_z), 32);
    t[0] = it.turn_w; t[1] = it.turn_x; t[2] = it.turn_y; t[3] = it.turn_z;
    w = rot[0]; x = rot[1]; y = rot[2]; z = rot[3];
    nq[0] = w*t[0] - x*t[1] - y*t[2] - z*t[3];
    nq[1] = w*t[1] + x*t[0] + y*t[3] - z*t[2];
    nq[2] = w*t[2] - x*t[3] + y*t[0] + z*t[1];
    nq[3] = w*t[3] + x*t[2] - y*t[1] + z*t[0];
    for (int i = 0; i < 4; i++) rot[i] = clip(nq[i] >>> 16, 18);
    half[0] = mul_floor(half[0], longint'(it.grow_x), 16);
    half[1] = mul_floor(half[1], longint'(it.grow_y), 16);
    half[2] = mul_floor(half[2], longint'(it.grow_z), 16);
    w = rot[0]; x = rot[1]; y = rot[2]; z = rot[3];
    one = 64'sd1 <<< 32;
    ax[0][0] = one - 2*(y*y + z*z);
    ax[0][1] = 2*(x*y + w*z);
    ax[0][2] = 2*(x*z - w*y);
    ax[1][0] = 2*(x*y - w*z);
    ax[1][1] = one - 2*(x*x + z*z);
    ax[1][2] = 2*(y*z + w*x);
    ax[2][0] = 2*(x*z + w*y);
    ax[2][1] = 2*(y*z - w*x);
    ax[2][2] = one - 2*(x*x + y*y);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        off[i][k] = mul_floor(ax[i][k] >>> 16, half[i], 16);
    for (int k = 0; k < 8; k++) begin
      sg[0] = (k & 2) ? -1 : 1;
      sg[1] = (k & 4) ? -1 : 1;
      sg[2] = (k & 1) ? -1 : 1;
      c.idx = 3'(k);
      v = clip(ctr[0] + sg[0]*off[0][0] + sg[1]*off[1][0] + sg[2]*off[2][0], 32);
      c.x = v[31:0];
      v = clip(ctr[1] + sg[0]*off[0][1] + sg[1]*off[1][1] + sg[2]*off[2][1], 32);
      c.y = v[31:0];
      v = clip(ctr[2] + sg[0]*off[0][2] + sg[1]*off[1][2] + sg[2]*off[2][2], 32);
      c.z = v[31:0];
      c.last = (k == 7);
      corner_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    corner_t c;
    if (!rst_n) begin
      ctr = '{0, 0, 0};
      half = '{65536, 65536, 65536};
      rot = '{65536, 0, 0, 0};
      corner_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) advance_pose(in_item_t'(in_tdata));
      if (out_tvalid && out_tready) begin
        if (corner_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected corner transfer %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          c = corner_q.pop_front();
          if (out_tdata[2:0] !== c.idx || out_tdata[34:3] !== c.x ||
              out_tdata[66:35] !== c.y || out_tdata[98:67] !== c.z ||
              out_tdata[103:99] !== '0 || out_tlast !== c.last) begin
            if (fail_count < 10)
              $display("corner mismatch: exp idx %0d x %h y %h z %h last %b, got %h last %b",
                       c.idx, c.x, c.y, c.z, c.last, out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= corner_q.size();
  end
endmodule

[dv/oriented_box_pose_and_corners_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_pose_and_corners_top_tb
// Drives pose changes into the box corner block with random gaps and random
// back-pressure; the checker predicts all eight corners of every transfer.
// ----------------------------------------------------------------------------
module oriented_box_pose_and_corners_top_tb;
  import obpc_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [103:0]        out_tdata;
  logic                out_tlast;
  int                  fail_count;
  int                  pending;
  int                  cycles;

  localparam int CYCLE_LIMIT = 600000;

  oriented_box_pose_and_corners_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  oriented_box_corner_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // Hold the item until the block takes it, then drop valid.
  task automatic send_pose(in_item_t it);
    in_tdata  = it;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  function automatic logic signed [17:0] near_turn(logic signed [17:0] base);
    return base + 18'($signed($urandom_range(4000)) - 2000);
  endfunction

  // Random pose change: mostly near-unit turns and near-one factors, so the
  // pose stays alive; some transfers use full-range noise.
  function automatic in_item_t rand_pose();
    in_item_t it;
    it.shift_x = $urandom;
    it.shift_y = $urandom;
    it.shift_z = $urandom;
    if ($urandom_range(99) < 75) begin
      it.turn_w = near_turn(18'sd65000);
      it.turn_x = near_turn(18'sd0);
      it.turn_y = near_turn(18'sd0);
      it.turn_z = near_turn(18'sd0);
    end else begin
      it.turn_w = 18'($urandom);
      it.turn_x = 18'($urandom);
      it.turn_y = 18'($urandom);
      it.turn_z = 18'($urandom);
    end
    if ($urandom_range(99) < 80) begin
      it.grow_x = 32'sd65536 + $signed($urandom_range(40000)) - 20000;
      it.grow_y = 32'sd65536 + $signed($urandom_range(40000)) - 20000;
      it.grow_z = 32'sd65536 + $signed($urandom_range(40000)) - 20000;
    end else begin
      it.grow_x = $urandom;
      it.grow_y = $urandom;
      it.grow_z = $urandom;
    end
    return it;
  endfunction

  function automatic in_item_t pose(int sx, int sy, int sz, int tw, int tx, int ty, int tz,
                                    int gx, int gy, int gz);
    in_item_t it;
    it.shift_x = sx; it.shift_y = sy; it.shift_z = sz;
    it.turn_w = 18'(tw); it.turn_x = 18'(tx); it.turn_y = 18'(ty); it.turn_z = 18'(tz);
    it.grow_x = gx; it.grow_y = gy; it.grow_z = gz;
    return it;
  endfunction

  // Receiver back-pressure on its own schedule.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      repeat ($urandom_range(20)) @(negedge clk);
      if ($urandom_range(3) != 0) begin
        out_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // Timeout watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int hi, lo;
    hi = 32'h7fffffff;
    lo = 32'h80000000;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: identity, saturating center, extreme turns, extreme factors,
    // negative factors, unnormalized turn.
    send_pose(pose(0, 0, 0, 65536, 0, 0, 0, 65536, 65536, 65536));
    send_pose(pose(hi, lo, hi, 65536, 0, 0, 0, 65536, 65536, 65536));
    send_pose(pose(hi, lo, hi, 65536, 0, 0, 0, 65536, 65536, 65536));
    send_pose(pose(lo, hi, -5, 46341, 46341, 0, 0, 131072, 65536, 32768));
    send_pose(pose(12345, -999, 7, 46341, 0, 46341, 0, -65536, 65536, -65536));
    send_pose(pose(0, 0, 0, 131071, 131071, 131071, 131071, hi, hi, hi));
    send_pose(pose(0, 0, 0, -131072, -131072, -131072, -131072, lo, 65536, hi));
    send_pose(pose(-1, 1, 0, 32768, 0, 0, 65535, 1, 2, 3));
    send_pose(pose(0, 0, 0, 65536, 0, 0, 0, hi, hi, hi));
    send_pose(pose(0, 0, 0, 65536, 0, 0, 0, hi, hi, hi));
    send_pose(pose(0, 0, 0, 65536, 0, 0, 0, 32768, -32768, 32768));
    send_pose(pose(100, 200, 300, 65536, 0, 0, 46341, 65536, 65536, 65536));
    send_pose(pose(0, 0, 0, 65536, 100, -100, 100, 65536, 65536, 65536));
    send_pose(pose(lo, lo, lo, 65536, 0, 0, 0, 65536, 65536, 65536));

    // Hold off the sender until every corner has drained.
    wait (pending == 0);
    @(negedge clk);

    for (int n = 0; n < 105; n++) send_pose(rand_pose());
    // Zero turn and zero factors collapse the pose for good, so they go last.
    send_pose(pose(1, 2, 3, 0, 0, 0, 0, 0, 0, 0));

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
